### rtl/core/linear_system_2x2_solver_macros.svh
// Assertion macros for the checker module
`ifndef LINEAR_SYSTEM_2X2_SOLVER_MACROS_SVH
`define LINEAR_SYSTEM_2X2_SOLVER_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle
`define LS2_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle
`define LS2_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/ls2x2_pkg.sv
package ls2x2_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 16;

  // Flags handed down the divider chain
  typedef struct packed {
    logic singular;
    logic neg0;
    logic neg1;
  } ls2x2_ctrl_t;

endpackage

### rtl/core/ls2x2_if.sv
interface ls2x2_in_if #(
  parameter int DATA_WIDTH = ls2x2_pkg::DATA_WIDTH_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a00;
  logic signed [DATA_WIDTH-1:0] a01;
  logic signed [DATA_WIDTH-1:0] a10;
  logic signed [DATA_WIDTH-1:0] a11;
  logic signed [DATA_WIDTH-1:0] b0;
  logic signed [DATA_WIDTH-1:0] b1;

  modport source (output valid, a00, a01, a10, a11, b0, b1, input ready);
  modport sink (input valid, a00, a01, a10, a11, b0, b1, output ready);
endinterface

interface ls2x2_out_if #(
  parameter int DATA_WIDTH = ls2x2_pkg::DATA_WIDTH_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x0;
  logic signed [DATA_WIDTH-1:0] x1;
  logic                         singular;
  logic                         overflow;

  modport source (output valid, x0, x1, singular, overflow, input ready);
  modport sink (input valid, x0, x1, singular, overflow, output ready);
endinterface

### rtl/core/linear_system_2x2_solver.sv
// Channel | Dir | Fields
// inp     | in  | a00 a01 a10 a11 b0 b1 (signed Q format)
// outp    | out | x0 x1 singular overflow
//
// One transaction per cycle unless stalled; the front stages feed a chain of
// division cells, one quotient bit per cell for each numerator, then the output register.
// The whole pipeline advances when the output register is empty or taken.
// rst clears all valid bits synchronously; payload is not reset.
module linear_system_2x2_solver #(
  parameter int DATA_WIDTH = ls2x2_pkg::DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = ls2x2_pkg::FRAC_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  ls2x2_in_if.sink     inp,
  ls2x2_out_if.source  outp
);
  localparam int MW = 2 * DATA_WIDTH;
  localparam int QW = MW + FRAC_BITS;
  localparam int NC = QW;

  logic en;
  assign en        = !outp.valid || outp.ready;
  assign inp.ready = en;

  logic [MW-1:0]          det_mag, n0_mag, n1_mag;
  logic                   fv;
  ls2x2_pkg::ls2x2_ctrl_t fctrl;

  ls2x2_front #(.DATA_WIDTH(DATA_WIDTH), .NW(MW + 1)) u_front (
    .clk, .rst, .en,
    .in_valid(inp.valid && inp.ready),
    .a00(inp.a00), .a01(inp.a01), .a10(inp.a10), .a11(inp.a11),
    .b0(inp.b0), .b1(inp.b1),
    .out_valid(fv), .det_mag, .n0_mag, .n1_mag, .ctrl(fctrl)
  );

  logic [MW-1:0]          c_den [NC+1];
  logic [MW-1:0]          c_r0  [NC+1];
  logic [MW-1:0]          c_r1  [NC+1];
  logic [QW-1:0]          c_q0  [NC+1];
  logic [QW-1:0]          c_q1  [NC+1];
  logic                   c_v   [NC+1];
  ls2x2_pkg::ls2x2_ctrl_t c_ctl [NC+1];

  assign c_den[0] = det_mag;
  assign c_r0[0]  = '0;
  assign c_r1[0]  = '0;
  assign c_q0[0]  = QW'({n0_mag, {FRAC_BITS{1'b0}}});
  assign c_q1[0]  = QW'({n1_mag, {FRAC_BITS{1'b0}}});
  assign c_v[0]   = fv;
  assign c_ctl[0] = fctrl;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    ls2x2_cell #(.MW(MW), .QW(QW)) u_cell (
      .clk, .rst, .en,
      .in_valid(c_v[i]), .den_in(c_den[i]), .r0_in(c_r0[i]), .r1_in(c_r1[i]),
      .q0_in(c_q0[i]), .q1_in(c_q1[i]), .ctrl_in(c_ctl[i]),
      .out_valid(c_v[i+1]), .den_out(c_den[i+1]), .r0_out(c_r0[i+1]),
      .r1_out(c_r1[i+1]), .q0_out(c_q0[i+1]), .q1_out(c_q1[i+1]),
      .ctrl_out(c_ctl[i+1])
    );
  end

  // Saturate a magnitude quotient with its sign
  function automatic logic [DATA_WIDTH:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] maxp;
    logic [DATA_WIDTH-1:0] r;
    logic ov;
    maxp = QW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    ov = 1'b0;
    if (!neg) begin
      if (q > maxp) begin
        ov = 1'b1;
        r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end else begin
        r = q[DATA_WIDTH-1:0];
      end
    end else begin
      if (q > maxp + QW'(1)) begin
        ov = 1'b1;
        r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
        r = -q[DATA_WIDTH-1:0];
      end
    end
    return {ov, r};
  endfunction

  logic [DATA_WIDTH:0] s0, s1;
  assign s0 = sat(c_q0[NC], c_ctl[NC].neg0);
  assign s1 = sat(c_q1[NC], c_ctl[NC].neg1);

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      outp.singular <= c_ctl[NC].singular;
      outp.x0       <= c_ctl[NC].singular ? '0 : s0[DATA_WIDTH-1:0];
      outp.x1       <= c_ctl[NC].singular ? '0 : s1[DATA_WIDTH-1:0];
      outp.overflow <= !c_ctl[NC].singular && (s0[DATA_WIDTH] || s1[DATA_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) outp.valid <= 1'b0;
    else if (en) outp.valid <= c_v[NC];
  end
endmodule

### rtl/core/ls2x2_front.sv
// Products, determinant and numerator magnitudes, two register stages
module ls2x2_front #(
  parameter int DATA_WIDTH = ls2x2_pkg::DATA_WIDTH_DEFAULT,
  parameter int NW         = 2 * DATA_WIDTH + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] a00,
  input  logic signed [DATA_WIDTH-1:0] a01,
  input  logic signed [DATA_WIDTH-1:0] a10,
  input  logic signed [DATA_WIDTH-1:0] a11,
  input  logic signed [DATA_WIDTH-1:0] b0,
  input  logic signed [DATA_WIDTH-1:0] b1,
  output logic                         out_valid,
  output logic [NW-2:0]                det_mag,
  output logic [NW-2:0]                n0_mag,
  output logic [NW-2:0]                n1_mag,
  output ls2x2_pkg::ls2x2_ctrl_t       ctrl
);
  localparam int PW = 2 * DATA_WIDTH;

  logic signed [PW-1:0] p_ad, p_bc, p_db0, p_bb1, p_ab1, p_cb0;
  logic                 v1;
  logic signed [NW-1:0] det_s, n0_s, n1_s;

  // Stage one: six products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ad  <= PW'(a00) * PW'(a11);
      p_bc  <= PW'(a01) * PW'(a10);
      p_db0 <= PW'(a11) * PW'(b0);
      p_bb1 <= PW'(a01) * PW'(b1);
      p_ab1 <= PW'(a00) * PW'(b1);
      p_cb0 <= PW'(a10) * PW'(b0);
    end
  end

  assign det_s = NW'(p_ad) - NW'(p_bc);
  assign n0_s  = NW'(p_db0) - NW'(p_bb1);
  assign n1_s  = NW'(p_ab1) - NW'(p_cb0);

  // Stage two: differences to sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      det_mag       <= det_s[NW-1] ? (NW-1)'(-det_s) : det_s[NW-2:0];
      n0_mag        <= n0_s[NW-1] ? (NW-1)'(-n0_s) : n0_s[NW-2:0];
      n1_mag        <= n1_s[NW-1] ? (NW-1)'(-n1_s) : n1_s[NW-2:0];
      ctrl.singular <= (det_s == '0);
      ctrl.neg0     <= n0_s[NW-1] ^ det_s[NW-1];
      ctrl.neg1     <= n1_s[NW-1] ^ det_s[NW-1];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end
endmodule

### rtl/core/ls2x2_cell.sv
// One restoring-division cell: two quotient bits per item, one per numerator
module ls2x2_cell #(
  parameter int MW = 64,
  parameter int QW = 96
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [MW-1:0]          den_in,
  input  logic [MW-1:0]          r0_in,
  input  logic [MW-1:0]          r1_in,
  input  logic [QW-1:0]          q0_in,
  input  logic [QW-1:0]          q1_in,
  input  ls2x2_pkg::ls2x2_ctrl_t ctrl_in,
  output logic                   out_valid,
  output logic [MW-1:0]          den_out,
  output logic [MW-1:0]          r0_out,
  output logic [MW-1:0]          r1_out,
  output logic [QW-1:0]          q0_out,
  output logic [QW-1:0]          q1_out,
  output ls2x2_pkg::ls2x2_ctrl_t ctrl_out
);
  // q carries the not yet consumed dividend bits in its top end
  logic [MW:0] t0, t1;
  logic        ge0, ge1;

  assign t0  = {r0_in, q0_in[QW-1]};
  assign t1  = {r1_in, q1_in[QW-1]};
  assign ge0 = t0 >= {1'b0, den_in};
  assign ge1 = t1 >= {1'b0, den_in};

  // Shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (en) begin
      den_out  <= den_in;
      r0_out   <= ge0 ? MW'(t0 - {1'b0, den_in}) : t0[MW-1:0];
      r1_out   <= ge1 ? MW'(t1 - {1'b0, den_in}) : t1[MW-1:0];
      q0_out   <= {q0_in[QW-2:0], ge0};
      q1_out   <= {q1_in[QW-2:0], ge1};
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end
endmodule

### rtl/core/ls2x2_checker.sv
`include "linear_system_2x2_solver_macros.svh"

module ls2x2_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic singular,
  input logic overflow
);
  // Flags never both set
  `LS2_ASSERT_IMP(a_flags, clk, rst, out_valid, !(singular && overflow))
  // Ready follows the output register
  `LS2_ASSERT_IMP(a_ready, clk, rst, !out_valid, in_ready)
  // A stalled transaction holds
  `LS2_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind linear_system_2x2_solver ls2x2_checker u_checker (
  .clk(clk), .rst(rst), .in_ready(inp.ready), .out_valid(outp.valid),
  .out_ready(outp.ready), .singular(outp.singular), .overflow(outp.overflow)
);

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = ls2x2_pkg::DATA_WIDTH_DEFAULT;
  localparam int FB = ls2x2_pkg::FRAC_BITS_DEFAULT;
  localparam int RANDOM_SYSTEMS = 1950;
  localparam int DRAIN_CYCLES = 2 + 2 * DW + FB + 1 + 20;

  localparam logic signed [DW-1:0] Q_MAX  = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN  = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] Q_ONE  = 1 <<< FB;
  localparam logic signed [DW-1:0] Q_ZERO = '0;
  localparam logic signed [DW-1:0] Q_LSB  = 1;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [DW-1:0] qval_t;

  typedef struct {
    qval_t a00, a01, a10, a11, b0, b1;
  } system_t;

  typedef struct {
    qval_t x0, x1;
    logic  singular, overflow;
  } solution_t;

  typedef struct {
    system_t   sys;
    bit        typed;
    solution_t sol;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ls2x2_in_if  #(.DATA_WIDTH(DW)) in_ch();
  ls2x2_out_if #(.DATA_WIDTH(DW)) out_ch();

  linear_system_2x2_solver #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk  (clk),
    .rst  (rst),
    .inp  (in_ch),
    .outp (out_ch)
  );

  solution_t pending_solutions[$];
  dir_row_t  dir_rows[$];
  int        err_count = 0;
  int        solved_count = 0;
  int        singular_count = 0;
  int        saturated_count = 0;

  always #5 clk = ~clk;

  // Divide with truncation toward zero, then clamp to the output range
  function automatic qval_t clamp_quotient(wide_t num, wide_t den, inout logic ovf);
    wide_t q;
    q = (num <<< FB) / den;
    if (q > wide_t'(Q_MAX)) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (q < wide_t'(Q_MIN)) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return qval_t'(q);
  endfunction

  // Solve A x = b by Cramer's rule at full precision
  function automatic solution_t cramer_solve(system_t s);
    solution_t r;
    wide_t det, n0, n1;
    logic ovf;
    det = wide_t'(s.a00) * wide_t'(s.a11) - wide_t'(s.a01) * wide_t'(s.a10);
    r = '{x0: '0, x1: '0, singular: 1'b1, overflow: 1'b0};
    if (det == 0) return r;
    n0 = wide_t'(s.a11) * wide_t'(s.b0) - wide_t'(s.a01) * wide_t'(s.b1);
    n1 = wide_t'(s.a00) * wide_t'(s.b1) - wide_t'(s.a10) * wide_t'(s.b0);
    ovf = 1'b0;
    r.x0 = clamp_quotient(n0, det, ovf);
    r.x1 = clamp_quotient(n1, det, ovf);
    r.singular = 1'b0;
    r.overflow = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string field, qval_t got, qval_t want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  task automatic add_row(qval_t a00, qval_t a01, qval_t a10, qval_t a11,
                         qval_t b0, qval_t b1, bit typed = 0,
                         qval_t x0 = 0, qval_t x1 = 0, logic sng = 0, logic ovf = 0);
    dir_row_t row;
    row.sys = '{a00, a01, a10, a11, b0, b1};
    row.typed = typed;
    row.sol = '{x0: x0, x1: x1, singular: sng, overflow: ovf};
    dir_rows.push_back(row);
  endtask

  function automatic qval_t small_q(int span);
    return qval_t'($urandom_range(0, 2 * span)) - qval_t'(span);
  endfunction

  function automatic qval_t corner_q();
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ZERO;
      3: return Q_LSB;
      4: return -Q_ONE;
      default: return Q_ONE;
    endcase
  endfunction

  // Draw a random system, mostly well-conditioned, with singular and
  // saturating shapes mixed in
  function automatic system_t random_system();
    system_t s;
    int k;
    case ($urandom_range(0, 9))
      0, 1: s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      2, 3, 4, 5: s = '{small_q(1 << 19), small_q(1 << 19), small_q(1 << 19),
                        small_q(1 << 19), small_q(1 << 22), small_q(1 << 22)};
      6: begin
        k = $urandom_range(0, 6) - 3;
        s.a00 = small_q(1 << 18);
        s.a01 = small_q(1 << 18);
        s.a10 = s.a00 * k;
        s.a11 = s.a01 * k;
        s.b0 = $urandom;
        s.b1 = $urandom;
      end
      7: s = '{small_q(4), small_q(4), small_q(4), small_q(4), $urandom, $urandom};
      8: s = '{corner_q(), corner_q(), corner_q(), corner_q(), corner_q(), corner_q()};
      default: begin
        k = $urandom_range(0, 4) - 2;
        s.a00 = small_q(1 << 20);
        s.a01 = small_q(1 << 20);
        s.a10 = s.a00 * k + small_q(2);
        s.a11 = s.a01 * k + small_q(2);
        s.b0 = small_q(1 << 20);
        s.b1 = small_q(1 << 20);
      end
    endcase
    return s;
  endfunction

  // Sender: hold each transaction until accepted, in bursts with gaps
  task automatic send_system(system_t s, solution_t want, inout int burst_left);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.a00 <= s.a00;
    in_ch.a01 <= s.a01;
    in_ch.a10 <= s.a10;
    in_ch.a11 <= s.a11;
    in_ch.b0 <= s.b0;
    in_ch.b1 <= s.b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_solutions.push_back(want);
    burst_left--;
  endtask

  initial begin
    int burst_left;
    system_t s;
    in_ch.valid = 1'b0;
    in_ch.a00 = '0;
    in_ch.a01 = '0;
    in_ch.a10 = '0;
    in_ch.a11 = '0;
    in_ch.b0 = '0;
    in_ch.b1 = '0;
    burst_left = 0;

    // Directed systems: zero, identity, extremes, singular and saturating cases
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0);
    add_row(Q_ONE, 0, 0, Q_ONE, 3 * Q_ONE, -2 * Q_ONE, 1, 3 * Q_ONE, -2 * Q_ONE, 0, 0);
    add_row(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1, 0, 0, 1, 0);
    add_row(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 0, 0, 1, 0);
    add_row(Q_LSB, 0, 0, Q_LSB, Q_MAX, Q_MIN, 1, Q_MAX, Q_MIN, 0, 1);
    add_row(Q_ONE, 0, 0, Q_ONE, Q_MIN, Q_MAX, 1, Q_MIN, Q_MAX, 0, 0);
    add_row(Q_ONE, 0, 0, Q_ONE, 0, 0, 1, 0, 0, 0, 0);
    add_row(-Q_ONE, 0, 0, -Q_ONE, Q_ONE, 0, 1, -Q_ONE, 0, 0, 0);
    add_row(Q_ONE, 2 * Q_ONE, 2 * Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE, 1, 0, 0, 1, 0);
    add_row(0, Q_ONE, Q_ONE, 0, 5 * Q_ONE, 7 * Q_ONE, 1, 7 * Q_ONE, 5 * Q_ONE, 0, 0);
    add_row(Q_LSB, 0, 0, -Q_LSB, -Q_MAX, Q_MAX, 1, Q_MIN, Q_MIN, 0, 1);
    add_row(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
    add_row(Q_MIN, 0, 0, Q_MIN, Q_MIN, Q_MAX);
    add_row(Q_MAX, 0, 0, Q_MAX, Q_LSB, -Q_LSB);
    add_row(Q_MIN, Q_MAX, Q_LSB, Q_MIN, Q_MAX, Q_MIN);
    add_row(3 * Q_ONE, Q_ONE, -Q_ONE, 2 * Q_ONE, 7 * Q_ONE, -Q_ONE);
    add_row(Q_LSB, Q_LSB, Q_LSB, 2 * Q_LSB, Q_MIN, Q_MIN);
    add_row(-Q_LSB, Q_MAX, Q_MIN, Q_LSB, -Q_ONE, Q_ONE);
    add_row(Q_ONE, Q_ONE, Q_ONE, Q_ONE + Q_LSB, Q_ONE, -Q_ONE);
    add_row(2 * Q_ONE, 0, 0, 3 * Q_ONE, Q_ONE, Q_ONE);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_system(dir_rows[i].sys,
                  dir_rows[i].typed ? dir_rows[i].sol : cramer_solve(dir_rows[i].sys),
                  burst_left);

    repeat (RANDOM_SYSTEMS) begin
      s = random_system();
      send_system(s, cramer_solve(s), burst_left);
    end
    in_ch.valid <= 1'b0;

    // Drain and finish
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Solved %0d systems: %0d singular, %0d saturated.",
             solved_count, singular_count, saturated_count);
    $display("Random mix of full-range, small, singular and near-singular matrices.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: stall on a rotating pattern, replaced now and then
  logic [15:0] ready_pattern = 16'hffff;
  int          pattern_age = 0;

  initial out_ch.ready = 1'b0;

  always @(posedge clk) begin
    if (pattern_age == 255) begin
      pattern_age <= 0;
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom) | 16'h0001;
    end else begin
      pattern_age <= pattern_age + 1;
      ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
    end
    out_ch.ready <= ready_pattern[15];
  end

  // Check each accepted transaction against the oldest pending solution
  always @(posedge clk) begin
    solution_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_solutions.size() == 0) begin
        $display("[%0t] unexpected result transaction", $time);
        err_count++;
      end else begin
        want = pending_solutions.pop_front();
        solved_count++;
        if (want.singular) singular_count++;
        if (want.overflow) saturated_count++;
        if (out_ch.x0 !== want.x0) report_mismatch("x0", out_ch.x0, want.x0);
        if (out_ch.x1 !== want.x1) report_mismatch("x1", out_ch.x1, want.x1);
        if (out_ch.singular !== want.singular)
          report_mismatch("singular", qval_t'(out_ch.singular), qval_t'(want.singular));
        if (out_ch.overflow !== want.overflow)
          report_mismatch("overflow", qval_t'(out_ch.overflow), qval_t'(want.overflow));
      end
    end
  end

  // Bound the run
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_solutions.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
